### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cbb_pkg.sv
`timescale 1ns / 1ps

package cbb_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int FIELD_W       = 16;
    localparam int NUM_CH        = 3;
    localparam int PADDR_W       = 3;

    localparam logic REG_IDX_ALPHA_MUL = 1'b0;

    typedef struct packed {
        logic [FIELD_W-1:0] mix_factor;
        logic [FIELD_W-1:0] base_red;
        logic [FIELD_W-1:0] base_green;
        logic [FIELD_W-1:0] base_blue;
        logic [FIELD_W-1:0] base_alpha;
        logic [FIELD_W-1:0] blend_red;
        logic [FIELD_W-1:0] blend_green;
        logic [FIELD_W-1:0] blend_blue;
        logic [FIELD_W-1:0] blend_alpha;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] out_red;
        logic [FIELD_W-1:0] out_green;
        logic [FIELD_W-1:0] out_blue;
        logic [FIELD_W-1:0] out_alpha;
    } t_out;

endpackage

### hdl/cbb_div_step.sv
`timescale 1ns / 1ps

module cbb_div_step #(
    parameter int FRAC_BITS = cbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_en,
    input  logic [cbb_pkg::NUM_CH-1:0][FRAC_BITS:0]        i_d,
    input  logic [cbb_pkg::NUM_CH-1:0][FRAC_BITS-1:0]      i_rem,
    input  logic [cbb_pkg::NUM_CH-1:0][FRAC_BITS-1:0]      i_quot,
    input  logic [cbb_pkg::NUM_CH-1:0]                     i_zero,
    input  logic [cbb_pkg::FIELD_W-1:0]                    i_alpha,
    output logic [cbb_pkg::NUM_CH-1:0][FRAC_BITS:0]        o_d,
    output logic [cbb_pkg::NUM_CH-1:0][FRAC_BITS-1:0]      o_rem,
    output logic [cbb_pkg::NUM_CH-1:0][FRAC_BITS-1:0]      o_quot,
    output logic [cbb_pkg::NUM_CH-1:0]                     o_zero,
    output logic [cbb_pkg::FIELD_W-1:0]                    o_alpha
);
    import cbb_pkg::*;

    localparam int VW = FRAC_BITS + 1;

    logic [NUM_CH-1:0][VW-1:0]        w_rem2;
    logic [NUM_CH-1:0]                w_ge;
    logic [NUM_CH-1:0][VW-1:0]        w_diff;
    logic [NUM_CH-1:0][FRAC_BITS-1:0] n_rem;
    logic [NUM_CH-1:0][FRAC_BITS-1:0] n_quot;

    logic [NUM_CH-1:0][VW-1:0]        r_d;
    logic [NUM_CH-1:0][FRAC_BITS-1:0] r_rem;
    logic [NUM_CH-1:0][FRAC_BITS-1:0] r_quot;
    logic [NUM_CH-1:0]                r_zero;
    logic [FIELD_W-1:0]               r_alpha;

    // one restoring step: remainder stays below the divisor
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_rem2[c] = {i_rem[c], 1'b0};
            w_ge[c]   = w_rem2[c] >= i_d[c];
            w_diff[c] = w_ge[c] ? (w_rem2[c] - i_d[c]) : w_rem2[c];
            n_rem[c]  = w_diff[c][FRAC_BITS-1:0];
            n_quot[c] = {i_quot[c][FRAC_BITS-2:0], w_ge[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= i_d;
            r_rem   <= n_rem;
            r_quot  <= n_quot;
            r_zero  <= i_zero;
            r_alpha <= i_alpha;
        end
    end

    assign o_d     = r_d;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_zero  = r_zero;
    assign o_alpha = r_alpha;

endmodule

### hdl/color_burn_blend.sv
// Pipeline stages: saturate, factor multiply, products and complements, divisor, divider steps, output.
// Throughput: one pixel per cycle while the output is not stalled; the divider yields one quotient bit per stage.
// Stalls ripple back only through full stages, empty stages keep accepting.
// Reset (synchronous, active low) empties the pipeline and clears alpha_multiply.
`timescale 1ns / 1ps

module color_burn_blend #(
    parameter int FRAC_BITS = cbb_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cbb_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cbb_pkg::t_out                 o_out_data
);
    import cbb_pkg::*;

    localparam int VW = FRAC_BITS + 1;
    localparam int PW = 2 * VW;
    localparam int DS = 4;
    localparam int NS = FRAC_BITS + 5;
    localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [VW-1:0] sat_one(input logic [FIELD_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 > 32'(ONE)) begin
            v32 = 32'(ONE);
        end
        return v32[VW-1:0];
    endfunction

    // config
    logic r_am;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_am <= 1'b0;
        end else if (w_wr && (paddr[PADDR_W-1] == REG_IDX_ALPHA_MUL)) begin
            r_am <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_IDX_ALPHA_MUL) begin
            prdata = 32'(r_am);
        end
    end

    // pipeline control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;
    logic [NS-1:0] w_vin;

    for (genvar k = 0; k < NS; k++) begin : g_en
        localparam logic [NS-1:0] LOW_MASK = NS'((64'd1 << k) - 64'd1);
        assign w_en[k] = i_out_ready || !(&(r_vld | LOW_MASK));
    end

    assign w_vin       = {r_vld[NS-2:0], i_in_valid};
    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // stage 0: saturate
    logic [VW-1:0]             r_p0_f;
    logic [VW-1:0]             r_p0_ba;
    logic [NUM_CH-1:0][VW-1:0] r_p0_c1;
    logic [NUM_CH-1:0][VW-1:0] r_p0_c2;
    logic [FIELD_W-1:0]        r_p0_alpha;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p0_f     <= sat_one(i_in_data.mix_factor);
            r_p0_ba    <= sat_one(i_in_data.blend_alpha);
            r_p0_c1[0] <= sat_one(i_in_data.base_red);
            r_p0_c1[1] <= sat_one(i_in_data.base_green);
            r_p0_c1[2] <= sat_one(i_in_data.base_blue);
            r_p0_c2[0] <= sat_one(i_in_data.blend_red);
            r_p0_c2[1] <= sat_one(i_in_data.blend_green);
            r_p0_c2[2] <= sat_one(i_in_data.blend_blue);
            r_p0_alpha <= i_in_data.base_alpha;
        end
    end

    // stage 1: factor times blend alpha when alpha_multiply is set, else factor as is
    logic [PW-1:0]             w_fm;
    logic [VW-1:0]             r_p1_f;
    logic [NUM_CH-1:0][VW-1:0] r_p1_c1;
    logic [NUM_CH-1:0][VW-1:0] r_p1_c2;
    logic [FIELD_W-1:0]        r_p1_alpha;

    assign w_fm = PW'(r_p0_f) * PW'(r_p0_ba);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p1_f     <= r_am ? w_fm[2*FRAC_BITS:FRAC_BITS] : r_p0_f;
            r_p1_c1    <= r_p0_c1;
            r_p1_c2    <= r_p0_c2;
            r_p1_alpha <= r_p0_alpha;
        end
    end

    // stage 2: f * c2, 1 - f, 1 - c1
    logic [NUM_CH-1:0][PW-1:0] w_fc;
    logic [NUM_CH-1:0][VW-1:0] r_p2_fc;
    logic [NUM_CH-1:0][VW-1:0] r_p2_a;
    logic [VW-1:0]             r_p2_nf;
    logic [FIELD_W-1:0]        r_p2_alpha;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_fc[c] = PW'(r_p1_f) * PW'(r_p1_c2[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_p2_fc[c] <= w_fc[c][2*FRAC_BITS:FRAC_BITS];
                r_p2_a[c]  <= ONE - r_p1_c1[c];
            end
            r_p2_nf    <= ONE - r_p1_f;
            r_p2_alpha <= r_p1_alpha;
        end
    end

    // stage 3: divisor; ratio >= 1 (or zero divisor) forces 0
    logic [NUM_CH-1:0][VW-1:0]        w_d;
    logic [NUM_CH-1:0]                w_z;
    logic [NUM_CH-1:0][VW-1:0]        r_p3_d;
    logic [NUM_CH-1:0][FRAC_BITS-1:0] r_p3_rem;
    logic [NUM_CH-1:0]                r_p3_zero;
    logic [FIELD_W-1:0]               r_p3_alpha;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_d[c] = r_p2_nf + r_p2_fc[c];
            w_z[c] = r_p2_a[c] >= w_d[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_p3_rem[c] <= w_z[c] ? '0 : r_p2_a[c][FRAC_BITS-1:0];
            end
            r_p3_d     <= w_d;
            r_p3_zero  <= w_z;
            r_p3_alpha <= r_p2_alpha;
        end
    end

    // divider stages
    logic [FRAC_BITS:0][NUM_CH-1:0][VW-1:0]        w_dc;
    logic [FRAC_BITS:0][NUM_CH-1:0][FRAC_BITS-1:0] w_rc;
    logic [FRAC_BITS:0][NUM_CH-1:0][FRAC_BITS-1:0] w_qc;
    logic [FRAC_BITS:0][NUM_CH-1:0]                w_zc;
    logic [FRAC_BITS:0][FIELD_W-1:0]               w_ac;

    assign w_dc[0] = r_p3_d;
    assign w_rc[0] = r_p3_rem;
    assign w_qc[0] = '0;
    assign w_zc[0] = r_p3_zero;
    assign w_ac[0] = r_p3_alpha;

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_div
        cbb_div_step #(
            .FRAC_BITS(FRAC_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_en    (w_en[DS+s]),
            .i_d     (w_dc[s]),
            .i_rem   (w_rc[s]),
            .i_quot  (w_qc[s]),
            .i_zero  (w_zc[s]),
            .i_alpha (w_ac[s]),
            .o_d     (w_dc[s+1]),
            .o_rem   (w_rc[s+1]),
            .o_quot  (w_qc[s+1]),
            .o_zero  (w_zc[s+1]),
            .o_alpha (w_ac[s+1])
        );
    end

    // output stage: round quotient up, 1 - q
    logic [NUM_CH-1:0][VW-1:0] w_q;
    logic [NUM_CH-1:0][VW-1:0] w_res;
    logic [NUM_CH-1:0][31:0]   w_res32;
    t_out                      n_out;
    t_out                      r_out;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_q[c]     = VW'(w_qc[FRAC_BITS][c]) + VW'(w_rc[FRAC_BITS][c] != '0);
            w_res[c]   = (w_zc[FRAC_BITS][c] || (w_q[c] == ONE)) ? '0 : (ONE - w_q[c]);
            w_res32[c] = 32'(w_res[c]);
        end
        n_out.out_red   = w_res32[0][FIELD_W-1:0];
        n_out.out_green = w_res32[1][FIELD_W-1:0];
        n_out.out_blue  = w_res32[2][FIELD_W-1:0];
        n_out.out_alpha = w_ac[FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

### hdl/cbb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [cbb_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input cbb_pkg::t_out               o_out_data
);
    import cbb_pkg::*;

    logic w_stall;
    logic w_idx0;
    logic w_cfg_wr;

    assign w_stall  = o_out_valid && !i_out_ready;
    assign w_idx0   = paddr[PADDR_W-1] == REG_IDX_ALPHA_MUL;
    assign w_cfg_wr = psel && penable && pwrite && pready && w_idx0;

    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    `ASSERT_RST(a_hold_out, i_clk, i_rst_n,
        w_stall |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")

    `ASSERT_RST(a_ready_drained, i_clk, i_rst_n,
        (!o_out_valid || i_out_ready) |-> o_in_ready, "request refused with room downstream")

    `ASSERT_RST(a_cfg_readback, i_clk, i_rst_n,
        w_cfg_wr |=> (!w_idx0 || (prdata[0] == $past(pwdata[0]))), "alpha_multiply readback")

endmodule

bind color_burn_blend cbb_checker u_cbb_checker (.*);
